// ===== src/gregorian_to_lunar_date_unit_assert.svh =====
// ----------------------------------------------------------------------------
// gregorian_to_lunar_date_unit_assert.svh
// assertion macros for the gregorian to lunar date unit
// ----------------------------------------------------------------------------
`ifndef GREGORIAN_TO_LUNAR_DATE_UNIT_ASSERT_SVH
`define GREGORIAN_TO_LUNAR_DATE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define GLU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("glu same-cycle check failed");

// next-cycle implication
`define GLU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("glu next-cycle check failed");

`else

`define GLU_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define GLU_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/glu_pkg.sv =====
// ----------------------------------------------------------------------------
// glu_pkg
// types, constants and tables of the gregorian to lunar date unit
// ----------------------------------------------------------------------------
package glu_pkg;

    localparam int TABLE_YEARS = 100;
    localparam int IDX_W       = $clog2(TABLE_YEARS);
    localparam int WORD_W      = 20;
    localparam int DAYS_W      = 16;

    localparam logic [10:0]        BASE_YEAR       = 11'd1921;
    localparam logic [8:0]         DAYS_PER_YEAR   = 9'd365;
    localparam logic [DAYS_W-1:0]  NEW_YEAR_OFFSET = 16'd38;
    localparam logic [WORD_W-1:0]  LONG_YEAR_MIN   = 20'd4095;
    localparam logic [4:0]         SHORT_MONTH     = 5'd29;
    localparam logic [3:0]         TOP_SHORT_YEAR  = 4'd11;
    localparam logic [3:0]         TOP_LONG_YEAR   = 4'd12;
    localparam logic [3:0]         FIRST_MONTH     = 4'd1;
    localparam logic [3:0]         LAST_MONTH      = 4'd12;

    // sexagenary cycle position of the base year
    localparam logic [3:0] STEM_BASE    = 4'd7;
    localparam logic [3:0] BRANCH_BASE  = 4'd9;
    localparam logic [3:0] STEM_LAST    = 4'd9;
    localparam logic [3:0] BRANCH_LAST  = 4'd11;

    typedef struct packed {
        logic [10:0] greg_year;
        logic [3:0]  greg_month;
        logic [4:0]  greg_day;
    } req_item_t;

    typedef struct packed {
        logic [10:0] lunar_year;
        logic [3:0]  stem_index;
        logic [3:0]  branch_index;
        logic [3:0]  lunar_month;
        logic        is_leap_month;
        logic [4:0]  lunar_day;
        logic        out_of_range;
    } rsp_item_t;

    localparam rsp_item_t FAULT_ITEM = '{
        lunar_year:    11'd0,
        stem_index:    4'd0,
        branch_index:  4'd0,
        lunar_month:   4'd0,
        is_leap_month: 1'b0,
        lunar_day:     5'd0,
        out_of_range:  1'b1
    };

    localparam logic [8:0] DAYS_BEFORE [12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    // low bits: month lengths, first month at the top bit; bits 19:16: leap month
    localparam logic [WORD_W-1:0] LUNAR_TAB [TABLE_YEARS] = '{
        20'd2635,   20'd333387, 20'd1701,   20'd1748,   20'd267701,
        20'd694,    20'd2391,   20'd133423, 20'd1175,   20'd396438,
        20'd3402,   20'd3749,   20'd331177, 20'd1453,   20'd694,
        20'd201326, 20'd2350,   20'd465197, 20'd3221,   20'd3402,
        20'd400202, 20'd2901,   20'd1386,   20'd267611, 20'd605,
        20'd2349,   20'd137515, 20'd2709,   20'd464533, 20'd1738,
        20'd2901,   20'd330421, 20'd1242,   20'd2651,   20'd199255,
        20'd1323,   20'd529706, 20'd3733,   20'd1706,   20'd398762,
        20'd2741,   20'd1206,   20'd267438, 20'd2647,   20'd1318,
        20'd204070, 20'd3477,   20'd461653, 20'd1386,   20'd2413,
        20'd330077, 20'd1197,   20'd2637,   20'd268877, 20'd3365,
        20'd531109, 20'd2900,   20'd2922,   20'd398042, 20'd2395,
        20'd1179,   20'd267415, 20'd2635,   20'd661067, 20'd1701,
        20'd1748,   20'd398772, 20'd2742,   20'd2391,   20'd330031,
        20'd1175,   20'd1611,   20'd200010, 20'd3749,   20'd527717,
        20'd1452,   20'd2742,   20'd332397, 20'd2350,   20'd3222,
        20'd268949, 20'd3402,   20'd3493,   20'd133973, 20'd1386,
        20'd464219, 20'd605,    20'd2349,   20'd334123, 20'd2709,
        20'd2890,   20'd267946, 20'd2773,   20'd592565, 20'd1210,
        20'd2651,   20'd395863, 20'd1323,   20'd2707,   20'd265877
    };

endpackage

// ===== src/glu_if.sv =====
// ----------------------------------------------------------------------------
// glu_if
// valid/ready channels of the gregorian to lunar date unit
// ----------------------------------------------------------------------------
interface glu_req_if;
    logic                 valid;
    logic                 ready;
    glu_pkg::req_item_t   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface glu_rsp_if;
    logic                 valid;
    logic                 ready;
    glu_pkg::rsp_item_t   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/gregorian_to_lunar_date_unit.sv =====
// ----------------------------------------------------------------------------
// gregorian_to_lunar_date_unit
// converts a gregorian date into a chinese lunar date by walking a year table
// ----------------------------------------------------------------------------
// usage
// - req channel: one gregorian date per transfer (year, month, day)
// - rsp channel: one lunar date per request, out_of_range set with all
//   other fields zero when the date falls outside 1921-02-08 .. table end
//   or the month field is invalid or the day field is zero
// - one request at a time: req.ready is high only while the unit is idle
// - steps: the day count comes first, then per table year a table rom read
//   and a walk over the months of that year (12 or 13), one month at a
//   time; the result then goes to the output register
// - an early fault skips the walk; dates at the end of the table or past
//   it walk every month of the table over the synchronous table rom
// - the result sits in an output register, so a new request is taken while
//   the previous result still waits for rsp.ready
// - if the receiver stalls with a result still pending, the finished next
//   result waits inside the unit until the output register frees up
// - reset (rst_n low, asynchronous) returns the unit to idle and drops any
//   pending result
// ----------------------------------------------------------------------------
`include "gregorian_to_lunar_date_unit_assert.svh"

module gregorian_to_lunar_date_unit
(
    input  logic          clk,
    input  logic          rst_n,
    glu_req_if.sink       req,
    glu_rsp_if.source     rsp
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CALC  = 5'b00010,
        ST_READ  = 5'b00100,
        ST_MONTH = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // captured request
    logic [10:0] y_reg;
    logic [3:0]  m_reg;
    logic [4:0]  d_reg;

    // walk state
    logic [glu_pkg::DAYS_W-1:0] left_reg, left_next;
    logic [glu_pkg::IDX_W-1:0]  idx_reg, idx_next;
    logic [3:0]                 cnt_reg, cnt_next;
    logic [10:0]                year_reg, year_next;
    logic [3:0]                 stem_reg, stem_next;
    logic [3:0]                 branch_reg, branch_next;

    // table rom output
    logic [glu_pkg::WORD_W-1:0] rom_q_reg;

    // finished result and output register
    glu_pkg::rsp_item_t res_reg, res_next;
    glu_pkg::rsp_item_t rsp_data_reg, rsp_data_next;
    logic               rsp_valid_reg, rsp_valid_next;

    // day count since lunar new year of the base year
    logic                       m_ok;
    logic                       in_ok;
    logic [6:0]                 dy;
    logic [8:0]                 dbm;
    logic [glu_pkg::DAYS_W-1:0] prod;
    logic [glu_pkg::DAYS_W-1:0] sum;
    logic                       day_ok;
    logic [glu_pkg::DAYS_W-1:0] left_c;

    // month walk
    logic                       long_year;
    logic [3:0]                 top;
    logic [3:0]                 pos;
    logic [4:0]                 month_len;
    logic                       hit;
    logic                       last;
    logic [3:0]                 leap_after;
    logic [4:0]                 mon_raw;
    logic [4:0]                 leap_after_1;
    logic [3:0]                 mon;
    logic                       leap;

    assign req.ready = (state_reg == ST_IDLE);
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    always_comb
    begin
        m_ok   = (m_reg inside {[glu_pkg::FIRST_MONTH:glu_pkg::LAST_MONTH]});
        in_ok  = m_ok && (d_reg != 5'd0) && (y_reg >= glu_pkg::BASE_YEAR);
        dy     = 7'(y_reg - glu_pkg::BASE_YEAR);
        dbm    = glu_pkg::DAYS_BEFORE[m_ok ? 4'(m_reg - 4'd1) : 4'd0];
        prod   = glu_pkg::DAYS_W'(dy) * glu_pkg::DAYS_W'(glu_pkg::DAYS_PER_YEAR);
        // gregorian leap day counts once february is over
        sum    = prod + glu_pkg::DAYS_W'(dy >> 2) + glu_pkg::DAYS_W'(dbm)
               + glu_pkg::DAYS_W'(d_reg)
               + glu_pkg::DAYS_W'((y_reg[1:0] == 2'd0) && (m_reg > 4'd2));
        day_ok = (sum > glu_pkg::NEW_YEAR_OFFSET);
        left_c = sum - glu_pkg::NEW_YEAR_OFFSET;
    end

    always_comb
    begin
        long_year    = (rom_q_reg >= glu_pkg::LONG_YEAR_MIN);
        top          = long_year ? glu_pkg::TOP_LONG_YEAR : glu_pkg::TOP_SHORT_YEAR;
        pos          = top - cnt_reg;
        month_len    = glu_pkg::SHORT_MONTH + 5'(rom_q_reg[{1'b0, pos}]);
        hit          = (left_reg <= glu_pkg::DAYS_W'(month_len));
        last         = (cnt_reg == top);
        leap_after   = rom_q_reg[19:16];
        mon_raw      = 5'(cnt_reg) + 5'd1;
        leap_after_1 = 5'(leap_after) + 5'd1;
        leap         = 1'b0;
        mon          = 4'(mon_raw);
        if (long_year && (mon_raw == leap_after_1))
        begin
            leap = 1'b1;
            mon  = leap_after;
        end
        else if (long_year && (mon_raw > leap_after_1))
        begin
            mon  = 4'(mon_raw - 5'd1);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        left_next      = left_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        year_next      = year_reg;
        stem_next      = stem_reg;
        branch_next    = branch_reg;
        res_next       = res_reg;
        rsp_data_next  = rsp_data_reg;
        rsp_valid_next = rsp_valid_reg;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (!in_ok || !day_ok)
                begin
                    res_next   = glu_pkg::FAULT_ITEM;
                    state_next = ST_DONE;
                end
                else
                begin
                    left_next   = left_c;
                    idx_next    = '0;
                    year_next   = glu_pkg::BASE_YEAR;
                    stem_next   = glu_pkg::STEM_BASE;
                    branch_next = glu_pkg::BRANCH_BASE;
                    state_next  = ST_READ;
                end
            end
            ST_READ:
            begin
                // table word for idx_reg lands in rom_q_reg at this edge
                cnt_next   = '0;
                state_next = ST_MONTH;
            end
            ST_MONTH:
            begin
                if (hit)
                begin
                    res_next.lunar_year    = year_reg;
                    res_next.stem_index    = stem_reg;
                    res_next.branch_index  = branch_reg;
                    res_next.lunar_month   = mon;
                    res_next.is_leap_month = leap;
                    res_next.lunar_day     = 5'(left_reg);
                    res_next.out_of_range  = 1'b0;
                    state_next             = ST_DONE;
                end
                else
                begin
                    left_next = left_reg - glu_pkg::DAYS_W'(month_len);
                    if (!last)
                    begin
                        cnt_next = cnt_reg + 4'd1;
                    end
                    else if (idx_reg == glu_pkg::IDX_W'(glu_pkg::TABLE_YEARS - 1))
                    begin
                        // past the end of the table
                        res_next   = glu_pkg::FAULT_ITEM;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        idx_next    = idx_reg + glu_pkg::IDX_W'(1);
                        year_next   = year_reg + 11'd1;
                        stem_next   = (stem_reg == glu_pkg::STEM_LAST) ? 4'd0
                                                                       : stem_reg + 4'd1;
                        branch_next = (branch_reg == glu_pkg::BRANCH_LAST) ? 4'd0
                                                                           : branch_reg + 4'd1;
                        state_next  = ST_READ;
                    end
                end
            end
            ST_DONE:
            begin
                // load the output register once it is free
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_data_next  = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            y_reg <= req.data.greg_year;
            m_reg <= req.data.greg_month;
            d_reg <= req.data.greg_day;
        end
        left_reg     <= left_next;
        year_reg     <= year_next;
        stem_reg     <= stem_next;
        branch_reg   <= branch_next;
        res_reg      <= res_next;
        rsp_data_reg <= rsp_data_next;
    end

    // year table rom, registered read
    always_ff @(posedge clk)
    begin
        rom_q_reg <= glu_pkg::LUNAR_TAB[idx_reg];
    end

    // a month is only examined with days still to place
    `GLU_ASSERT_IMP(a_walk_left_nonzero, clk, rst_n, state_reg == ST_MONTH, left_reg != '0)
    // month step never runs past the last month of the year
    `GLU_ASSERT_IMP(a_walk_in_year, clk, rst_n, state_reg == ST_MONTH, cnt_reg <= top)
    // cycle counters stay in range
    `GLU_ASSERT_IMP(a_cycle_range, clk, rst_n, state_reg == ST_MONTH,
        (stem_reg <= glu_pkg::STEM_LAST) && (branch_reg <= glu_pkg::BRANCH_LAST))
    // a finished result reaches the output register
    `GLU_ASSERT_NXT(a_done_loads, clk, rst_n, (state_reg == ST_DONE) && (!rsp.valid || rsp.ready),
        rsp.valid && (rsp.data == $past(res_reg)))
    // a fault result carries no date
    `GLU_ASSERT_IMP(a_fault_clean, clk, rst_n, rsp.valid && rsp.data.out_of_range,
        (rsp.data.lunar_day == '0) && (rsp.data.lunar_month == '0))

endmodule

// ===== test/gregorian_to_lunar_date_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gregorian_to_lunar_date_unit_tb
// self-checking bench for the gregorian to lunar date unit: dates go in on
// the request channel, a built-in calendar predictor works out each lunar
// date, and every response is compared field by field in arrival order
// ----------------------------------------------------------------------------
module gregorian_to_lunar_date_unit_tb;

    // ------------------------------------------------------------------------
    // clock, reset and channels
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #5 clk = ~clk;

    glu_req_if req_ch ();
    glu_rsp_if rsp_ch ();

    gregorian_to_lunar_date_unit u_top
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // ------------------------------------------------------------------------
    // shared bench state
    // ------------------------------------------------------------------------
    glu_pkg::rsp_item_t lunar_q[$];        // lunar dates still owed by the unit
    glu_pkg::rsp_item_t due_date;          // oldest owed date, taken at each transfer
    int unsigned        mismatches = 0;
    bit                 idle_en = 1'b0;    // random gaps and stalls on both sides
    bit                 hold_rsp = 1'b0;   // long receiver hold-off, set by its own process
    int                 rsp_wait = 0;      // cycles left before the receiver takes again

    // ------------------------------------------------------------------------
    // calendar predictor
    // ------------------------------------------------------------------------
    // day 1 is lunar new year 1921; the count is walked month by month over
    // the year table until the remaining count fits inside a month
    function automatic glu_pkg::rsp_item_t lunar_of(glu_pkg::req_item_t q);
        int        y;
        int        m;
        int        d;
        int        dy;
        int        remain;
        int        i;
        int        p;
        int        mlen;
        int        top;
        int        hit_year;
        int        hit_pos;
        int        hit_top;
        int        mon;
        int        leap_after;
        int        cyc;
        bit        found;
        bit        leap;
        logic [glu_pkg::WORD_W-1:0] word;
        logic [glu_pkg::WORD_W-1:0] hit_word;
        glu_pkg::rsp_item_t r;

        y = int'(q.greg_year);
        m = int'(q.greg_month);
        d = int'(q.greg_day);
        found = 1'b0;
        leap = 1'b0;
        hit_year = 0;
        hit_pos = 0;
        hit_top = 0;
        hit_word = '0;
        r = glu_pkg::FAULT_ITEM;

        // bad month, day zero, or a year before the table
        if (m < int'(glu_pkg::FIRST_MONTH) || m > int'(glu_pkg::LAST_MONTH) || d < 1
            || y < int'(glu_pkg::BASE_YEAR))
            return r;

        dy = y - int'(glu_pkg::BASE_YEAR);
        remain = dy * int'(glu_pkg::DAYS_PER_YEAR) + dy / 4
               + int'(glu_pkg::DAYS_BEFORE[m - 1]) + d - int'(glu_pkg::NEW_YEAR_OFFSET);
        // every fourth year is a leap year over the whole span
        if (y % 4 == 0 && m > 2)
            remain = remain + 1;
        // before lunar new year 1921
        if (remain < 1)
            return r;

        for (i = 0; i < glu_pkg::TABLE_YEARS && !found; i++)
        begin
            word = glu_pkg::LUNAR_TAB[i];
            top = (word < glu_pkg::LONG_YEAR_MIN) ? int'(glu_pkg::TOP_SHORT_YEAR)
                                                  : int'(glu_pkg::TOP_LONG_YEAR);
            for (p = top; p >= 0 && !found; p--)
            begin
                mlen = int'(glu_pkg::SHORT_MONTH) + int'(word[p]);
                if (remain <= mlen)
                begin
                    found = 1'b1;
                    hit_year = i;
                    hit_pos = p;
                    hit_top = top;
                    hit_word = word;
                end
                else
                    remain = remain - mlen;
            end
        end

        // past the last month of the table
        if (!found)
            return r;

        mon = hit_top - hit_pos + 1;
        if (hit_top == int'(glu_pkg::TOP_LONG_YEAR))
        begin
            leap_after = int'(hit_word >> 16);
            if (mon == leap_after + 1)
            begin
                leap = 1'b1;
                mon = leap_after;
            end
            else if (mon > leap_after + 1)
                mon = mon - 1;
        end

        y = int'(glu_pkg::BASE_YEAR) + hit_year;
        cyc = (y - 4) % 60;
        r.lunar_year    = 11'(y);
        r.stem_index    = 4'(cyc % 10);
        r.branch_index  = 4'(cyc % 12);
        r.lunar_month   = 4'(mon);
        r.is_leap_month = leap;
        r.lunar_day     = 5'(remain);
        r.out_of_range  = 1'b0;
        return r;
    endfunction

    function automatic glu_pkg::req_item_t date_of(int y, int m, int d);
        glu_pkg::req_item_t q;
        q.greg_year  = 11'(y);
        q.greg_month = 4'(m);
        q.greg_day   = 5'(d);
        return q;
    endfunction

    // a well-formed date from 1921 to 2021; the latest ones fall past the table
    function automatic glu_pkg::req_item_t rand_valid_date();
        int y;
        int m;
        int mdays;
        y = $urandom_range(int'(glu_pkg::BASE_YEAR),
                           int'(glu_pkg::BASE_YEAR) + glu_pkg::TABLE_YEARS);
        m = $urandom_range(int'(glu_pkg::FIRST_MONTH), int'(glu_pkg::LAST_MONTH));
        mdays = (m == int'(glu_pkg::LAST_MONTH)) ? 31
              : int'(glu_pkg::DAYS_BEFORE[m]) - int'(glu_pkg::DAYS_BEFORE[m - 1]);
        if (m == 2 && y % 4 == 0)
            mdays = mdays + 1;
        return date_of(y, m, $urandom_range(1, mdays));
    endfunction

    // any bit pattern the request fields can carry
    function automatic glu_pkg::req_item_t rand_any_date();
        return date_of($urandom_range(0, 2047), $urandom_range(0, 15), $urandom_range(0, 31));
    endfunction

    // ------------------------------------------------------------------------
    // request side: one transfer per call
    // ------------------------------------------------------------------------
    // valid stays high from one date to the next when no gap is drawn, so
    // it only ever gets one nonblocking write per edge
    task automatic send_date(glu_pkg::req_item_t q);
        int gap;
        gap = idle_en ? $urandom_range(0, 14) : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= q;
        do
            @(posedge clk);
        while (!req_ch.ready);
        // accepted at this edge: the unit now owes one lunar date
        lunar_q.push_back(lunar_of(q));
    endtask

    // drop valid and wait for every owed response
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (lunar_q.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // response side: random stalls and the field-by-field check
    // ------------------------------------------------------------------------
    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (lunar_q.size() == 0)
                begin
                    $display("%0t ns: unexpected response, expected none actual %p",
                             $time, rsp_ch.data);
                    mismatches++;
                end
                else
                begin
                    due_date = lunar_q.pop_front();
                    check_field("lunar_year", 32'(due_date.lunar_year),
                                32'(rsp_ch.data.lunar_year));
                    check_field("stem_index", 32'(due_date.stem_index),
                                32'(rsp_ch.data.stem_index));
                    check_field("branch_index", 32'(due_date.branch_index),
                                32'(rsp_ch.data.branch_index));
                    check_field("lunar_month", 32'(due_date.lunar_month),
                                32'(rsp_ch.data.lunar_month));
                    check_field("is_leap_month", 32'(due_date.is_leap_month),
                                32'(rsp_ch.data.is_leap_month));
                    check_field("lunar_day", 32'(due_date.lunar_day),
                                32'(rsp_ch.data.lunar_day));
                    check_field("out_of_range", 32'(due_date.out_of_range),
                                32'(rsp_ch.data.out_of_range));
                end
                rsp_wait = idle_en ? $urandom_range(0, 14) : 0;
            end
            else if (rsp_wait > 0)
                rsp_wait--;
            rsp_ch.ready <= (rsp_wait == 0) && !hold_rsp;
        end
        else
            rsp_ch.ready <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // field extremes, both ends of the table and the fault cases
    task automatic test_edge_dates();
        idle_en = 1'b1;
        send_date(date_of(1921, 2, 8));     // first day of the table
        send_date(date_of(1921, 2, 7));     // one day before the table
        send_date(date_of(1921, 1, 1));
        send_date(date_of(0, 1, 1));        // all-zero year
        send_date(date_of(1920, 12, 31));
        send_date(date_of(1024, 6, 15));
        send_date(date_of(2047, 12, 31));   // all-ones year and day, far past the table
        send_date(date_of(2021, 2, 10));    // around the last lunar new year's eve
        send_date(date_of(2021, 2, 11));
        send_date(date_of(2021, 2, 12));
        send_date(date_of(2021, 12, 31));   // past the last table month
        send_date(date_of(2020, 12, 31));
        send_date(date_of(1950, 0, 10));    // month zero
        send_date(date_of(1950, 13, 10));   // month past december
        send_date(date_of(1950, 15, 31));
        send_date(date_of(1950, 6, 0));     // day zero
        send_date(date_of(1950, 2, 30));    // runs on into march
        send_date(date_of(1950, 1, 31));
        send_date(date_of(1924, 2, 29));    // gregorian leap day
        send_date(date_of(2000, 3, 1));
        send_date(date_of(1985, 2, 20));    // a lunar new year
        wait_drained();
    endtask

    // dates inside intercalary months and just around them
    task automatic test_leap_months();
        idle_en = 1'b0;
        send_date(date_of(1922, 7, 1));
        send_date(date_of(1922, 7, 25));
        send_date(date_of(1984, 12, 10));
        send_date(date_of(2001, 6, 1));
        send_date(date_of(2017, 8, 1));
        send_date(date_of(2020, 6, 1));
        send_date(date_of(2020, 7, 1));
        wait_drained();
    endtask

    // receiver holds off while quick dates keep coming, so the output
    // register and the internal slot fill and the request side stalls
    task automatic test_backpressure();
        int k;
        idle_en = 1'b0;
        fork
            begin
                hold_rsp <= 1'b1;
                repeat (400) @(posedge clk);
                hold_rsp <= 1'b0;
            end
        join_none
        for (k = 0; k < 12; k++)
        begin
            if (k % 2 == 0)
                send_date(date_of(1921, $urandom_range(0, 15), $urandom_range(0, 31)));
            else
                send_date(date_of(1921, $urandom_range(3, 12), $urandom_range(1, 28)));
        end
        wait_drained();
    endtask

    // mostly well-formed dates across the whole table, some raw noise;
    // idling comes and goes in stretches
    task automatic test_random_dates();
        int k;
        for (k = 0; k < 390; k++)
        begin
            if (k % 40 == 0)
                idle_en = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) == 0)
                send_date(rand_any_date());
            else
                send_date(rand_valid_date());
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // run
    // ------------------------------------------------------------------------
    initial
    begin
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_edge_dates();
        test_leap_months();
        test_backpressure();
        test_random_dates();

        // nothing owed any more; give the unit a few cycles to show strays
        repeat (20) @(posedge clk);
        if (mismatches == 0 && lunar_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // watchdog: several times the slowest correct run
    initial
    begin
        #40_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
